[hw/rtl/pctb_pkg.sv]
// Shared types, constants and the channel blend function for the pixel tint blender.
package pctb_pkg;

  localparam int TINT_LAYERS = 3;
  localparam int LAYER_SLOTS = 3;
  localparam int PIPE_LAT    = TINT_LAYERS + 1;

  localparam int CH_W        = 8;
  localparam int LEVEL_W     = 7;
  localparam int COLOR_W     = 24;
  localparam int LAYER_CNT_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [LEVEL_W-1:0]     LEVEL_MAX      = 7'd100;
  localparam logic [CH_W-1:0]        FULL_ALPHA_MIN = 8'd250;
  localparam logic [CH_W-1:0]        BLEND_ONE      = 8'd128;
  localparam logic [LAYER_CNT_W-1:0] LAYER_LIMIT    = LAYER_CNT_W'(TINT_LAYERS);

  localparam logic [CFG_IDX_W-1:0] REG_L0_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L0_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L1_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L2_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd6;

  typedef struct packed {
    logic [LAYER_SLOTS-1:0][COLOR_W-1:0] color;
    logic [LAYER_SLOTS-1:0][LEVEL_W-1:0] level;
    logic [LAYER_CNT_W-1:0]              active;
  } pctb_cfg_t;

  typedef struct packed {
    logic                                valid;
    logic [CH_W-1:0]                     alpha;
    logic [CH_W-1:0]                     red;
    logic [CH_W-1:0]                     green;
    logic [CH_W-1:0]                     blue;
    logic [LAYER_CNT_W-1:0]              layers;
    logic [TINT_LAYERS-1:0][LEVEL_W-1:0] level;
  } pctb_pix_t;

  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0]    ch,
                                               input logic [CH_W-1:0]    tint,
                                               input logic [LEVEL_W-1:0] level);
    logic [CH_W-1:0]   wgt;
    logic [2*CH_W-1:0] p_src;
    logic [2*CH_W-1:0] p_tint;
    logic [2*CH_W-1:0] sum;
    wgt    = BLEND_ONE - {1'b0, level};
    p_src  = {{CH_W{1'b0}}, ch} * {{CH_W{1'b0}}, wgt};
    p_tint = {{(CH_W+1){1'b0}}, level} * {{CH_W{1'b0}}, tint};
    sum    = p_src + p_tint;
    return sum[CH_W+6:7];
  endfunction

endpackage

[hw/rtl/pctb_cfg.sv]
// Configuration register file with level saturation.
module pctb_cfg import pctb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pctb_cfg_t             cfg
);

  pctb_cfg_t          cfg_r;
  pctb_cfg_t          cfg_nxt;
  logic [LEVEL_W-1:0] level_sat;

  assign level_sat = (cfg_data[LEVEL_W-1:0] > LEVEL_MAX) ? LEVEL_MAX : cfg_data[LEVEL_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_L0_COLOR: cfg_nxt.color[0] = cfg_data[COLOR_W-1:0];
        REG_L0_LEVEL: cfg_nxt.level[0] = level_sat;
        REG_L1_COLOR: cfg_nxt.color[1] = cfg_data[COLOR_W-1:0];
        REG_L1_LEVEL: cfg_nxt.level[1] = level_sat;
        REG_L2_COLOR: cfg_nxt.color[2] = cfg_data[COLOR_W-1:0];
        REG_L2_LEVEL: cfg_nxt.level[2] = level_sat;
        REG_ACTIVE:   cfg_nxt.active   = cfg_data[LAYER_CNT_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/pctb_scale.sv]
// Entry stage: captures the pixel and, for alpha below FULL_ALPHA_MIN, scales every layer level by alpha.
module pctb_scale import pctb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [CH_W-1:0] alpha,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  input  pctb_cfg_t       cfg,
  output pctb_pix_t       pix_o
);

  logic                   valid_r;
  pctb_pix_t              data_r;
  pctb_pix_t              data_nxt;
  logic [LAYER_CNT_W-1:0] n_layers;
  logic                   transparent;

  assign transparent = (alpha == '0);
  assign n_layers    = (cfg.active > LAYER_LIMIT) ? LAYER_LIMIT : cfg.active;

  always_comb begin
    logic [2*CH_W-2:0] prod;
    data_nxt.valid  = 1'b1;
    data_nxt.alpha  = alpha;
    // A transparent pixel leaves as all zeros, so no layer touches it.
    data_nxt.red    = transparent ? '0 : red;
    data_nxt.green  = transparent ? '0 : green;
    data_nxt.blue   = transparent ? '0 : blue;
    data_nxt.layers = transparent ? '0 : n_layers;
    for (int k = 0; k < TINT_LAYERS; k++) begin
      prod = {{(CH_W-1){1'b0}}, alpha} * {{(2*CH_W-1-LEVEL_W){1'b0}}, cfg.level[k]};
      data_nxt.level[k] = (alpha < FULL_ALPHA_MIN) ? prod[CH_W+LEVEL_W-1:CH_W] : cfg.level[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    pix_o       = data_r;
    pix_o.valid = valid_r;
  end

endmodule

[hw/rtl/pctb_layer.sv]
// One blend stage: mixes a tint color into the three channels of a pixel that uses this layer.
module pctb_layer import pctb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LAYER_CNT_W-1:0] layer_idx,
  input  logic [COLOR_W-1:0]     color,
  input  logic [LEVEL_W-1:0]     level,
  input  pctb_pix_t              pix_i,
  output pctb_pix_t              pix_o
);

  logic      valid_r;
  pctb_pix_t data_r;
  pctb_pix_t data_nxt;
  logic      apply;

  assign apply = (pix_i.layers > layer_idx);

  always_comb begin
    data_nxt = pix_i;
    if (apply) begin
      data_nxt.red   = blend_ch(pix_i.red,   color[7:0],   level);
      data_nxt.green = blend_ch(pix_i.green, color[15:8],  level);
      data_nxt.blue  = blend_ch(pix_i.blue,  color[23:16], level);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pix_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_i.valid) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    pix_o       = data_r;
    pix_o.valid = valid_r;
  end

endmodule

[hw/rtl/pixel_color_tint_blend.sv]
// Top level of the alpha-weighted color tint blender.
// One ARGB pixel is taken in every clock cycle while busy is low (busy is high only during
// reset), and its tinted result appears on the out_ ports once the entry stage and every
// layer stage have registered it, marked by out_valid for exactly one cycle. The pipeline
// has one entry stage that scales the layer levels by alpha and one blend stage per tint
// layer; an unused layer stage passes the pixel through unchanged. Results cannot be held
// off, so the receiver must take each beat in the cycle it is shown. Configuration writes
// take effect at the next clock edge and should be made while no pixel is in flight.
module pixel_color_tint_blend import pctb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CH_W-1:0]       in_alpha,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  output logic                  out_valid,
  output logic [CH_W-1:0]       out_alpha,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pctb_cfg_t cfg;
  pctb_pix_t pix [TINT_LAYERS+1];
  logic      accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  pctb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pctb_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .alpha  (in_alpha),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .cfg    (cfg),
    .pix_o  (pix[0])
  );

  for (genvar k = 0; k < TINT_LAYERS; k++) begin : g_layer
    pctb_layer u_layer (
      .clk       (clk),
      .rst_n     (rst_n),
      .layer_idx (LAYER_CNT_W'(k)),
      .color     (cfg.color[k]),
      .level     (pix[k].level[k]),
      .pix_i     (pix[k]),
      .pix_o     (pix[k+1])
    );
  end

  assign out_valid = pix[TINT_LAYERS].valid;
  assign out_alpha = pix[TINT_LAYERS].alpha;
  assign out_red   = pix[TINT_LAYERS].red;
  assign out_green = pix[TINT_LAYERS].green;
  assign out_blue  = pix[TINT_LAYERS].blue;

endmodule

[hw/rtl/pctb_checker.sv]
// Port-level checks for the tint blender, bound to the top level.
module pctb_checker import pctb_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [CH_W-1:0]       in_alpha,
  input logic                  out_valid,
  input logic [CH_W-1:0]       out_alpha,
  input logic [CH_W-1:0]       out_red,
  input logic [CH_W-1:0]       out_green,
  input logic [CH_W-1:0]       out_blue
);

  // Every beat shown was accepted exactly the pipeline latency earlier.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without a matching input beat");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted input beat produced no result");

  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == $past(in_alpha, PIPE_LAT)))
    else $error("alpha changed on its way through");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alpha == '0)) |->
      ((out_red == '0) && (out_green == '0) && (out_blue == '0)))
    else $error("transparent pixel has nonzero color");

endmodule

bind pixel_color_tint_blend pctb_checker u_pctb_checker (.*);

[tb/sv/pctb_tint_checker.sv]
// Checker for the pixel tint blender: predicts each tinted pixel and compares it with the result.
module pctb_tint_checker import pctb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [CH_W-1:0]       in_alpha,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic                  out_valid,
  input  logic [CH_W-1:0]       out_alpha,
  input  logic [CH_W-1:0]       out_red,
  input  logic [CH_W-1:0]       out_green,
  input  logic [CH_W-1:0]       out_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } argb_t;

  logic [COLOR_W-1:0]     tint_color [LAYER_SLOTS];
  logic [LEVEL_W-1:0]     tint_level [LAYER_SLOTS];
  logic [LAYER_CNT_W-1:0] layer_count;
  argb_t                  tinted_pixels_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] ch, logic [CH_W-1:0] tint,
                                                   int unsigned lvl);
    int unsigned sum;
    sum = int'(ch) * (128 - lvl) + lvl * int'(tint);
    return CH_W'(sum >> 7);
  endfunction

  function automatic argb_t tint_pixel(argb_t src);
    argb_t       px;
    int unsigned layers;
    int unsigned lvl;
    int          k;
    px = src;
    if (src.alpha == '0) return '0;
    layers = layer_count;
    if (layers > TINT_LAYERS) layers = TINT_LAYERS;
    for (k = 0; k < layers; k++) begin
      lvl = tint_level[k];
      // Translucent pixels get a proportionally weaker tint.
      if (src.alpha < FULL_ALPHA_MIN) lvl = (int'(src.alpha) * lvl) >> 8;
      px.red   = mix_channel(px.red,   tint_color[k][7:0],   lvl);
      px.green = mix_channel(px.green, tint_color[k][15:8],  lvl);
      px.blue  = mix_channel(px.blue,  tint_color[k][23:16], lvl);
    end
    return px;
  endfunction

  always @(posedge clk) begin
    argb_t            got;
    argb_t            want;
    logic [LEVEL_W-1:0] lv;
    if (!rst_n) begin
      for (int k = 0; k < LAYER_SLOTS; k++) begin
        tint_color[k] = '0;
        tint_level[k] = '0;
      end
      layer_count = '0;
      tinted_pixels_due.delete();
    end else begin
      if (out_valid) begin
        got = '{out_alpha, out_red, out_green, out_blue};
        if (tinted_pixels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: a=%0d r=%0d g=%0d b=%0d",
                     got.alpha, got.red, got.green, got.blue);
        end else begin
          want = tinted_pixels_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: expected a=%0d r=%0d g=%0d b=%0d, got a=%0d r=%0d g=%0d b=%0d",
                       want.alpha, want.red, want.green, want.blue,
                       got.alpha, got.red, got.green, got.blue);
          end
        end
      end
      if (start && !busy)
        tinted_pixels_due.push_back(tint_pixel('{in_alpha, in_red, in_green, in_blue}));
      if (cfg_we) begin
        // Levels keep only the low seven bits and saturate at the maximum.
        lv = cfg_data[LEVEL_W-1:0];
        if (lv > LEVEL_MAX) lv = LEVEL_MAX;
        case (cfg_index)
          REG_L0_COLOR: tint_color[0] = cfg_data;
          REG_L0_LEVEL: tint_level[0] = lv;
          REG_L1_COLOR: tint_color[1] = cfg_data;
          REG_L1_LEVEL: tint_level[1] = lv;
          REG_L2_COLOR: tint_color[2] = cfg_data;
          REG_L2_LEVEL: tint_level[2] = lv;
          REG_ACTIVE:   layer_count   = cfg_data[LAYER_CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = tinted_pixels_due.size();
  end

endmodule

[tb/sv/pixel_color_tint_blend_test.sv]
// Top of the pixel tint blender testbench: clock, reset, stimulus and the final verdict.
module pixel_color_tint_blend_test;
  import pctb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 90;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CH_W-1:0]       in_alpha, in_red, in_green, in_blue;
  logic                  out_valid;
  logic [CH_W-1:0]       out_alpha, out_red, out_green, out_blue;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_color_tint_blend uut (
    .clk, .rst_n, .start, .busy,
    .in_alpha, .in_red, .in_green, .in_blue,
    .out_valid, .out_alpha, .out_red, .out_green, .out_blue,
    .cfg_we, .cfg_index, .cfg_data
  );

  pctb_tint_checker checker_i (
    .clk, .rst_n, .start, .busy,
    .in_alpha, .in_red, .in_green, .in_blue,
    .out_valid, .out_alpha, .out_red, .out_green, .out_blue,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // The run ends if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("pixel_color_tint_blend verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_tints(logic [CFG_DATA_W-1:0] c0, logic [CFG_DATA_W-1:0] l0,
                            logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] l1,
                            logic [CFG_DATA_W-1:0] c2, logic [CFG_DATA_W-1:0] l2,
                            logic [CFG_DATA_W-1:0] layers);
    write_reg(REG_L0_COLOR, c0);
    write_reg(REG_L0_LEVEL, l0);
    write_reg(REG_L1_COLOR, c1);
    write_reg(REG_L1_LEVEL, l1);
    write_reg(REG_L2_COLOR, c2);
    write_reg(REG_L2_LEVEL, l2);
    write_reg(REG_ACTIVE, layers);
    // Writes to the unused index must change nothing.
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // One beat: optional idle gap, then hold start until the block takes the pixel.
  task automatic send_pixel(logic [CH_W-1:0] a, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    in_alpha = a;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(3))
      0: return CFG_DATA_W'(LEVEL_MAX);
      1: return CFG_DATA_W'($urandom_range(127));
      2: return CFG_DATA_W'($urandom);
      default: return '0;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_alpha();
    case ($urandom_range(5))
      0: return '0;
      1: return CH_W'($urandom_range(255, 250));
      2: return CH_W'($urandom_range(249, 1));
      default: return CH_W'($urandom);
    endcase
  endfunction

  initial begin
    int idle_pct;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_alpha  = '0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: no layers, pixels pass through except transparent ones.
    send_pixel(8'd0,   8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd12,  8'd200, 8'd77,  0);
    send_pixel(8'd1,   8'd255, 8'd0,   8'd128, 0);
    drain();

    // Over-range level writes saturate; full white and full black tints.
    load_tints(24'hFFFFFF, 24'd127, 24'h000000, 24'd100, 24'hFF0080, 24'd101, 24'd3);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0,   8'd0,   8'd0,   0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd250, 8'd128, 8'd64,  8'd200, 0);
    send_pixel(8'd249, 8'd128, 8'd64,  8'd200, 0);
    send_pixel(8'd1,   8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd0,   8'd255, 8'd0,   0);
    send_pixel(8'd2,   8'd0,   8'd0,   8'd255, 0);
    drain();

    // Only the first layer, then two layers.
    load_tints(24'h123456, 24'd64, 24'hABCDEF, 24'hFFFFE4, 24'h00FF00, 24'd0, 24'd1);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd100, 0);
    send_pixel(8'd100, 8'd10,  8'd20,  8'd30,  0);
    drain();
    write_reg(REG_ACTIVE, 24'd2);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd100, 0);
    send_pixel(8'd7,   8'd99,  8'd1,   8'd254, 0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase < 5) ? 35 : (phase < 10) ? 81 : 0;
      if (phase == 3)
        load_tints(24'hFFFFFF, 24'd100, 24'hFFFFFF, 24'd100, 24'hFFFFFF, 24'd100, 24'd3);
      else if (phase == 8)
        load_tints(24'h000000, 24'd100, 24'h000000, 24'd100, 24'h000000, 24'd100, 24'd3);
      else if (phase == 12)
        load_tints(24'h000000, 24'd0, 24'h000000, 24'd0, 24'h000000, 24'd0, 24'd0);
      else
        load_tints(CFG_DATA_W'($urandom), pick_level(), CFG_DATA_W'($urandom), pick_level(),
                   CFG_DATA_W'($urandom), pick_level(), CFG_DATA_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(pick_alpha(), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), idle_pct);
        // Now and then the sender stops until every result is back.
        if (n == PHASE_ITEMS / 2 && phase % 4 == 1) drain();
      end
      drain();
    end

    repeat (PIPE_LAT + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_color_tint_blend verification clean");
    end else begin
      $display("pixel_color_tint_blend verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pctb_pkg.sv
hw/rtl/pctb_cfg.sv
hw/rtl/pctb_scale.sv
hw/rtl/pctb_layer.sv
hw/rtl/pixel_color_tint_blend.sv
hw/rtl/pctb_checker.sv
tb/sv/pctb_tint_checker.sv
tb/sv/pixel_color_tint_blend_test.sv
